// File: hdl/bhra_pkg.sv
package bhra_pkg;

    // Shared divider sizing: longest dividend is degree-seconds times 32
    localparam int DIV_DVD_W = 53;
    localparam int DIV_DSR_W = 34;
    localparam int DIV_CNT_W = 6;

    // Quotient bits produced per division kind
    localparam logic [DIV_CNT_W-1:0] STEPS_BUCKET = 6'd12;
    localparam logic [DIV_CNT_W-1:0] STEPS_RATIO  = 6'd53;

    localparam logic [11:0] SECONDS_PER_HOUR = 12'd3600;

    // Degree-hours by reciprocal: ds / 3600 = ((ds >> 4) * ceil(2^52 / 225)) >> 52,
    // exact for every 44-bit operand; the product is built from four 22 x 23 bit terms
    localparam int          HOUR_OP_W  = 44;
    localparam int          HOUR_HALF  = 22;
    localparam int          HOUR_PP_W  = 45;
    localparam int          HOUR_ACC_W = 89;
    localparam int          HOUR_SHIFT = 52;
    localparam logic [44:0] HOUR_RECIP = 45'h1234_5678_9ABD;

    // Field widths
    localparam int TEMP_W  = 12;
    localparam int WIDTH_W = 10;
    localparam int GAP_W   = 16;
    localparam int TIME_W  = 32;
    localparam int DSEC_W  = 48;
    localparam int LOW_W   = 18;
    localparam int DH_W    = 37;
    localparam int RATIO_W = 16;
    localparam int PROD_W  = 28;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_TEMP = 2'd0;
    localparam logic [1:0] CFG_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_MAX_GAP  = 2'd2;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: hdl/bhra_div.sv
module bhra_div
    import bhra_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_DSR_W-1:0] rem_reg, rem_next;
    logic [DIV_DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_DVD_W-1:0] quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DSR_W:0]   trial;
    logic                 fits;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[DIV_DVD_W-1]};
    assign fits  = trial >= {1'b0, req.divisor};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            dvd_next  = req.dividend;
            quo_next  = '0;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DIV_DSR_W'(trial - {1'b0, req.divisor})
                            : trial[DIV_DSR_W-1:0];
            dvd_next = {dvd_reg[DIV_DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[DIV_DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: hdl/bhra_store.sv
module bhra_store
    import bhra_pkg::*;
#(
    parameter int BUCKETS = 16,
    parameter int IDX_W   = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [TIME_W-1:0] rd_runtime,
    output logic [DSEC_W-1:0] rd_dsec,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [TIME_W-1:0] wr_runtime,
    input  logic [DSEC_W-1:0] wr_dsec
);

    logic [TIME_W-1:0]  rt_mem [BUCKETS];
    logic [DSEC_W-1:0]  ds_mem [BUCKETS];
    logic [BUCKETS-1:0] valid_reg;
    logic [TIME_W-1:0]  rt_q_reg;
    logic [DSEC_W-1:0]  ds_q_reg;
    logic               hit_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rt_mem[wr_addr] <= wr_runtime;
            ds_mem[wr_addr] <= wr_dsec;
        end
    end

    // Mark written entries; reset makes every entry read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rt_q_reg <= rt_mem[rd_addr];
        ds_q_reg <= ds_mem[rd_addr];
        hit_reg  <= valid_reg[rd_addr];
    end

    assign rd_runtime = hit_reg ? rt_q_reg : '0;
    assign rd_dsec    = hit_reg ? ds_q_reg : '0;

endmodule

// File: hdl/binned_heating_runtime_accumulator_core.sv
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_tvalid/s_tready  | tuser: cmd; tdata: tick sample or read index
// m_       | out       | m_tvalid/m_tready  | tuser: index_ok; tdata: bucket figures
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A tick that credits nothing returns to idle; a crediting tick reads and writes its bucket, which
// the shared divider finds (12 quotient bits) when the outdoor offset is positive. A read past the
// last bucket goes straight to output; else it runs 4 multiply-accumulate steps for the hours, then
// 53 quotient bits for the ratio unless the runtime is zero. Every read then waits on m_tready.
// The input is not ready from acceptance until the item is finished.
// Synchronous reset; bucket stores are cleared by per-entry valid bits, no sweep.
module binned_heating_runtime_accumulator_core
    import bhra_pkg::*;
#(
    parameter int BUCKETS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input requests
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [0:0]   s_tuser,    // [0] cmd
    // [0] heat_active, [12:1] indoor_temp, [13] indoor_valid, [25:14] outdoor_temp,
    // [26] outdoor_valid, [58:27] now_s, [66:59] bucket_index, [71:67] zero
    input  logic [71:0]  s_tdata,
    // Results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [0:0]   m_tuser,    // [0] index_ok
    // [17:0] bucket_low_temp, [49:18] runtime_s, [86:50] degree_hours,
    // [102:87] dd_per_run_hour, [134:103] total_runtime_s, [135] zero
    output logic [135:0] m_tdata,
    // Configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_TICK  = 10'b0000000010,
        ST_BDIV  = 10'b0000000100,
        ST_TRD   = 10'b0000001000,
        ST_TUPD  = 10'b0000010000,
        ST_READ  = 10'b0000100000,
        ST_RDATA = 10'b0001000000,
        ST_DH    = 10'b0010000000,
        ST_RATIO = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [TEMP_W-1:0]  min_temp_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [GAP_W-1:0]   max_gap_reg;

    // Accumulator state
    logic               prev_active_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic [TIME_W-1:0]  total_reg;

    // Captured request
    logic               heat_reg, ivalid_reg, ovalid_reg;
    logic [TEMP_W-1:0]  indoor_reg, outdoor_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [7:0]         idx_reg;

    // Working registers
    logic [GAP_W-1:0]   dt_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [IDX_W-1:0]   bucket_reg;
    logic               ok_reg;
    logic [LOW_W-1:0]   low_reg;
    logic [TIME_W-1:0]  rt_reg;
    logic [DSEC_W-1:0]  ds_reg;
    logic [DH_W-1:0]    dh_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [1:0]         dh_step_reg;
    logic [HOUR_ACC_W-1:0] dh_acc_reg;

    // Tick arithmetic
    logic               active;
    logic [TEMP_W:0]    temp_diff;
    logic [TEMP_W:0]    out_off;
    logic               out_off_pos;
    logic [TIME_W-1:0]  dt_raw;
    logic [GAP_W-1:0]   dt_cap;
    logic [WIDTH_W-1:0] width_div;
    logic [IDX_W-1:0]   bucket_q;
    logic [DSEC_W:0]    ds_sum;
    logic [DIV_DSR_W-1:0] rt_x3;
    logic               idx_in_range;
    logic [LOW_W-1:0]   low_calc;

    // Degree-hours multiply-accumulate
    logic [HOUR_OP_W-1:0]  hour_op;
    logic [HOUR_HALF-1:0]  hour_a;
    logic [HOUR_HALF:0]    hour_b;
    logic [HOUR_PP_W-1:0]  hour_pp;
    logic [HOUR_ACC_W-1:0] hour_term;
    logic [HOUR_ACC_W-1:0] hour_sum;

    // Store and divider hookup
    logic [IDX_W-1:0]   rd_addr;
    logic [TIME_W-1:0]  rd_runtime;
    logic [DSEC_W-1:0]  rd_dsec;
    logic               wr_en;
    logic [TIME_W-1:0]  wr_runtime;
    logic [DSEC_W-1:0]  wr_dsec;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Active tick test and credited seconds
    assign active = heat_reg && ivalid_reg && ovalid_reg &&
                    ($signed(indoor_reg) > $signed(outdoor_reg));
    assign temp_diff = {indoor_reg[TEMP_W-1], indoor_reg}
                     - {outdoor_reg[TEMP_W-1], outdoor_reg};
    assign dt_raw = now_reg - last_time_reg;
    assign dt_cap = (dt_raw > {{(TIME_W-GAP_W){1'b0}}, max_gap_reg})
                  ? max_gap_reg : dt_raw[GAP_W-1:0];

    // Outdoor offset from the lowest bucket edge
    assign out_off = {outdoor_reg[TEMP_W-1], outdoor_reg}
                   - {min_temp_reg[TEMP_W-1], min_temp_reg};
    assign out_off_pos = !out_off[TEMP_W] && (out_off != '0);
    assign width_div = (width_reg == '0) ? WIDTH_W'(1) : width_reg;

    // Clamp the bucket quotient to the top bucket
    assign bucket_q = (div_rsp.quotient[11:0] >= 12'(BUCKETS))
                    ? IDX_W'(BUCKETS - 1) : div_rsp.quotient[IDX_W-1:0];

    assign ds_sum = {1'b0, rd_dsec} + {{(DSEC_W+1-PROD_W){1'b0}}, prod_reg};
    assign rt_x3  = {2'b00, rt_reg} + {1'b0, rt_reg, 1'b0};

    assign idx_in_range = (idx_reg < 8'(BUCKETS));
    assign low_calc = {{(LOW_W-TEMP_W){min_temp_reg[TEMP_W-1]}}, min_temp_reg}
                    + ({{(LOW_W-WIDTH_W){1'b0}}, width_reg} * {{(LOW_W-8){1'b0}}, idx_reg});

    // One partial product of (ds >> 4) times the hour reciprocal per step
    assign hour_op = ds_reg[DSEC_W-1:4];
    assign hour_a  = dh_step_reg[1] ? hour_op[HOUR_OP_W-1:HOUR_HALF] : hour_op[HOUR_HALF-1:0];
    assign hour_b  = dh_step_reg[0] ? HOUR_RECIP[HOUR_PP_W-1:HOUR_HALF]
                                    : {1'b0, HOUR_RECIP[HOUR_HALF-1:0]};
    assign hour_pp = {{(HOUR_HALF+1){1'b0}}, hour_a} * {{HOUR_HALF{1'b0}}, hour_b};

    // Align the partial product to its weight
    always_comb begin
        case (dh_step_reg)
            2'd0:    hour_term = {{(HOUR_ACC_W-HOUR_PP_W){1'b0}}, hour_pp};
            2'd3:    hour_term = {hour_pp, {(2*HOUR_HALF){1'b0}}};
            default: hour_term = {{HOUR_HALF{1'b0}}, hour_pp, {HOUR_HALF{1'b0}}};
        endcase
    end

    assign hour_sum = dh_acc_reg + hour_term;

    assign rd_addr    = (state_reg == ST_TRD) ? bucket_reg : idx_reg[IDX_W-1:0];
    assign wr_en      = (state_reg == ST_TUPD);
    assign wr_runtime = rd_runtime + {{(TIME_W-GAP_W){1'b0}}, dt_reg};
    assign wr_dsec    = ds_sum[DSEC_W] ? {DSEC_W{1'b1}} : ds_sum[DSEC_W-1:0];

    // Divider requests per state
    always_comb begin
        div_req = '0;
        case (state_reg)
            ST_TICK: begin
                div_req.start    = active && prev_active_reg && (dt_cap != '0) && out_off_pos;
                div_req.steps    = STEPS_BUCKET;
                div_req.dividend = {out_off[TEMP_W-1:0], {(DIV_DVD_W-TEMP_W){1'b0}}};
                div_req.divisor  = DIV_DSR_W'(width_div);
            end
            ST_BDIV: begin
                div_req.divisor  = DIV_DSR_W'(width_div);
            end
            ST_DH: begin
                div_req.start    = (dh_step_reg == 2'd3) && (rt_reg != '0);
                div_req.steps    = STEPS_RATIO;
                div_req.dividend = {ds_reg, 5'b00000};
                div_req.divisor  = rt_x3;
            end
            ST_RATIO: begin
                div_req.divisor  = rt_x3;
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = s_tuser[0] ? ST_READ : ST_TICK;
            end
            ST_TICK: begin
                if (!(active && prev_active_reg && (dt_cap != '0))) begin
                    state_next = ST_IDLE;
                end else if (out_off_pos) begin
                    state_next = ST_BDIV;
                end else begin
                    state_next = ST_TRD;
                end
            end
            ST_BDIV: begin
                if (div_rsp.done) state_next = ST_TRD;
            end
            ST_TRD:  state_next = ST_TUPD;
            ST_TUPD: state_next = ST_IDLE;
            ST_READ: state_next = idx_in_range ? ST_RDATA : ST_OUT;
            ST_RDATA: state_next = ST_DH;
            ST_DH: begin
                if (dh_step_reg == 2'd3) state_next = (rt_reg != '0) ? ST_RATIO : ST_OUT;
            end
            ST_RATIO: begin
                if (div_rsp.done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_temp_reg <= 12'hEC0;
            width_reg    <= 10'd80;
            max_gap_reg  <= 16'd300;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MIN_TEMP: min_temp_reg <= cfg_data[TEMP_W-1:0];
                CFG_WIDTH:    width_reg    <= cfg_data[WIDTH_W-1:0];
                CFG_MAX_GAP:  max_gap_reg  <= cfg_data[GAP_W-1:0];
                default:      ;
            endcase
        end
    end

    // Tick history and total runtime
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_active_reg <= 1'b0;
            last_time_reg   <= '0;
            total_reg       <= '0;
        end else begin
            if (state_reg == ST_TICK) begin
                prev_active_reg <= active;
                last_time_reg   <= now_reg;
            end
            if (state_reg == ST_TUPD) begin
                total_reg <= total_reg + {{(TIME_W-GAP_W){1'b0}}, dt_reg};
            end
        end
    end

    // Payload capture and working registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            heat_reg    <= s_tdata[0];
            indoor_reg  <= s_tdata[12:1];
            ivalid_reg  <= s_tdata[13];
            outdoor_reg <= s_tdata[25:14];
            ovalid_reg  <= s_tdata[26];
            now_reg     <= s_tdata[58:27];
            idx_reg     <= s_tdata[66:59];
        end
        case (state_reg)
            ST_TICK: begin
                dt_reg     <= dt_cap;
                prod_reg   <= {{(PROD_W-TEMP_W){1'b0}}, temp_diff[TEMP_W-1:0]}
                            * {{(PROD_W-GAP_W){1'b0}}, dt_cap};
                bucket_reg <= '0;
            end
            ST_BDIV: begin
                if (div_rsp.done) bucket_reg <= bucket_q;
            end
            ST_READ: begin
                ok_reg    <= idx_in_range;
                low_reg   <= idx_in_range ? low_calc : '0;
                rt_reg    <= '0;
                ds_reg    <= '0;
                dh_reg    <= '0;
                ratio_reg <= '0;
            end
            ST_RDATA: begin
                rt_reg      <= rd_runtime;
                ds_reg      <= rd_dsec;
                dh_step_reg <= '0;
                dh_acc_reg  <= '0;
            end
            ST_DH: begin
                dh_acc_reg  <= hour_sum;
                dh_step_reg <= dh_step_reg + 2'd1;
                if (dh_step_reg == 2'd3) dh_reg <= hour_sum[HOUR_SHIFT +: DH_W];
            end
            ST_RATIO: begin
                if (div_rsp.done) begin
                    ratio_reg <= (div_rsp.quotient[DIV_DVD_W-1:RATIO_W] != '0)
                               ? {RATIO_W{1'b1}} : div_rsp.quotient[RATIO_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // Result port
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tuser  = ok_reg;
    assign m_tdata  = {1'b0, ok_reg ? total_reg : {TIME_W{1'b0}},
                       ratio_reg, dh_reg, rt_reg, low_reg};

    bhra_store #(
        .BUCKETS (BUCKETS),
        .IDX_W   (IDX_W)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_addr    (rd_addr),
        .rd_runtime (rd_runtime),
        .rd_dsec    (rd_dsec),
        .wr_en      (wr_en),
        .wr_addr    (bucket_reg),
        .wr_runtime (wr_runtime),
        .wr_dsec    (wr_dsec)
    );

    bhra_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

endmodule
